// ===== rtl/flc_pkg.sv =====
`timescale 1ns / 1ps

package flc_pkg;

    localparam int ID_W      = 23;
    localparam int BYTES_W   = 11;
    localparam int SEG_W     = 6;
    localparam int OVF_W     = 10;
    localparam int WAY_OUT_W = 2;
    localparam int WAY_IDX_W = 4;
    localparam int STAMP_W   = 32;

    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] way;
    } t_way_sel;

endpackage

// ===== rtl/flc_set_ram.sv =====
`timescale 1ns / 1ps

module flc_set_ram #(
    parameter int DATA_W = 200,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/flc_way_sel.sv =====
`timescale 1ns / 1ps

module flc_way_sel #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 17
) (
    input  logic [WAYS-1:0]                           i_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]                i_tag,
    input  logic [WAYS-1:0][flc_pkg::STAMP_W-1:0]     i_stamp,
    input  logic [TAG_W-1:0]                          i_lookup_tag,
    output flc_pkg::t_way_sel                         o_sel
);

    import flc_pkg::*;

    logic                 hit_found;
    logic                 inv_found;
    logic [WAY_IDX_W-1:0] hit_way;
    logic [WAY_IDX_W-1:0] inv_way;
    logic [WAY_IDX_W-1:0] lru_way;
    logic [STAMP_W-1:0]   best;

    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!hit_found && i_valid[i] && (i_tag[i] == i_lookup_tag)) begin
                hit_found = 1'b1;
                hit_way   = WAY_IDX_W'(i);
            end
            if (!inv_found && !i_valid[i]) begin
                inv_found = 1'b1;
                inv_way   = WAY_IDX_W'(i);
            end
        end
        // strict compare keeps the lowest way on equal stamps
        best    = i_stamp[0];
        lru_way = '0;
        for (int i = 1; i < WAYS; i++) begin
            if (i_stamp[i] < best) begin
                best    = i_stamp[i];
                lru_way = WAY_IDX_W'(i);
            end
        end
        o_sel.hit = hit_found;
        if (hit_found) begin
            o_sel.way = hit_way;
        end else if (inv_found) begin
            o_sel.way = inv_way;
        end else begin
            o_sel.way = lru_way;
        end
    end

endmodule

// ===== rtl/fiber_lru_cache_lookup.sv =====
`timescale 1ns / 1ps

// fiber access lookup in a set-associative tag store with timestamp lru
// request channel: drive i_fiber_id / i_fiber_bytes with start; the request is
//   taken on a clock edge where start is high and busy is low
// result channel: o_result_valid pulses for one cycle per segment looked up,
//   with o_segment, o_hit, o_way_used, o_overflow_miss_bytes and o_last;
//   the receiver cannot stall, so results must be captured when they appear
// config: i_cfg_we writes i_cfg_wdata into fiber_mode (reset 1); write only
//   while busy is low and no result is pending
// timing: the set row is read on the accept edge; each segment is looked up in
//   the update state and its result is registered onto the ports, one
//   result per cycle, since later segments of the same fiber reuse the
//   forwarded row instead of the memory
// a request holds busy while its segments are looked up (always one segment in
//   first-line mode); a zero-length fiber in line mode gives no result and
//   leaves busy low
// reset: busy stays high while a clearing pass invalidates every set row
//   (SETS rows, 4096 by default), one row per cycle
module fiber_lru_cache_lookup #(
    parameter int LINE_BYTES   = 16,
    parameter int WAYS         = 4,
    parameter int SETS         = 4096,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic [flc_pkg::ID_W-1:0]        i_fiber_id,
    input  logic [flc_pkg::BYTES_W-1:0]     i_fiber_bytes,
    output logic                            o_result_valid,
    output logic [flc_pkg::SEG_W-1:0]       o_segment,
    output logic                            o_hit,
    output logic [flc_pkg::WAY_OUT_W-1:0]   o_way_used,
    output logic [flc_pkg::OVF_W-1:0]       o_overflow_miss_bytes,
    output logic                            o_last
);

    import flc_pkg::*;

    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_SW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W   = SEG_W + ID_W - SET_W;
    localparam int ROW_W   = WAYS * (1 + TAG_W + STAMP_W);
    localparam int LINE_SH = $clog2(LINE_BYTES);
    localparam int BYTE_CW = 13;
    localparam int NSEG_W  = SEG_W + 1;
    localparam logic [BYTE_CW-1:0] CAP = BYTE_CW'(MAX_SEGMENTS * LINE_BYTES);
    localparam logic [BYTE_CW-1:0] LINE_C = BYTE_CW'(LINE_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [SET_W-1:0]     r_clr_idx;
    logic [STAMP_W-1:0]   r_stamp;
    logic                 r_fiber_mode;
    logic                 r_out_valid;

    logic [SET_W-1:0]     r_set;
    logic [ID_W-SET_W-1:0] r_id_hi;
    logic [SEG_W-1:0]     r_seg;
    logic [SEG_W-1:0]     r_last_seg;
    logic [OVF_W-1:0]     r_over;
    logic                 r_first;
    logic [ROW_W-1:0]     r_row;

    logic [SEG_W-1:0]     r_out_seg;
    logic                 r_out_hit;
    logic [WAY_OUT_W-1:0] r_out_way;
    logic [OVF_W-1:0]     r_out_over;
    logic                 r_out_last;

    logic                 accept;
    logic [BYTE_CW-1:0]   bytes_ext;
    logic [BYTE_CW-1:0]   bytes_c;
    logic [BYTE_CW-1:0]   nseg_sum;
    logic [NSEG_W-1:0]    nseg;
    logic [BYTE_CW-1:0]   over_full;
    logic [OVF_W-1:0]     over;

    logic [ROW_W-1:0]                   ram_rdata;
    logic [ROW_W-1:0]                   row_in;
    logic [ROW_W-1:0]                   row_out;
    logic                               ram_we;
    logic [SET_W-1:0]                   ram_waddr;
    logic [ROW_W-1:0]                   ram_wdata;
    logic [WAYS-1:0]                    cur_valid;
    logic [WAYS-1:0][TAG_W-1:0]         cur_tag;
    logic [WAYS-1:0][STAMP_W-1:0]       cur_stamp;
    logic [WAYS-1:0]                    nxt_valid;
    logic [WAYS-1:0][TAG_W-1:0]         nxt_tag;
    logic [WAYS-1:0][STAMP_W-1:0]       nxt_stamp;
    logic [TAG_W-1:0]                   lookup_tag;
    logic [STAMP_W-1:0]                 stamp_next;
    logic                               seg_done;
    t_way_sel                           sel;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    // request decode: clamp, segment count, mode 0 overflow bytes
    always_comb begin
        bytes_ext = BYTE_CW'(i_fiber_bytes);
        bytes_c   = (bytes_ext > CAP) ? CAP : bytes_ext;
        nseg_sum  = bytes_c + BYTE_CW'(LINE_BYTES - 1);
        nseg      = NSEG_W'(nseg_sum >> LINE_SH);
        over_full = bytes_c - LINE_C;
        over      = (bytes_c > LINE_C) ? over_full[OVF_W-1:0] : '0;
    end

    flc_set_ram #(
        .DATA_W (ROW_W),
        .ADDR_W (SET_W)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_fiber_id[SET_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // later segments share the set, so they use the row just written
    assign row_in = r_first ? ram_rdata : r_row;
    assign {cur_valid, cur_tag, cur_stamp} = row_in;
    assign lookup_tag = {r_seg, r_id_hi};
    assign stamp_next = r_stamp + 1'b1;

    flc_way_sel #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_way_sel (
        .i_valid      (cur_valid),
        .i_tag        (cur_tag),
        .i_stamp      (cur_stamp),
        .i_lookup_tag (lookup_tag),
        .o_sel        (sel)
    );

    always_comb begin
        nxt_valid = cur_valid;
        nxt_tag   = cur_tag;
        nxt_stamp = cur_stamp;
        nxt_valid[sel.way[WAY_SW-1:0]] = 1'b1;
        nxt_tag[sel.way[WAY_SW-1:0]]   = lookup_tag;
        nxt_stamp[sel.way[WAY_SW-1:0]] = stamp_next;
    end

    assign row_out   = {nxt_valid, nxt_tag, nxt_stamp};
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_UPDATE);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_set;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : row_out;
    assign seg_done  = (r_seg == r_last_seg);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == SET_W'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (!r_fiber_mode || (nseg != '0))) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (seg_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_stamp      <= '0;
            r_fiber_mode <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_UPDATE);
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_UPDATE) begin
                r_stamp <= stamp_next;
            end
            if (i_cfg_we) begin
                r_fiber_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set   <= i_fiber_id[SET_W-1:0];
            r_id_hi <= i_fiber_id[ID_W-1:SET_W];
            r_seg   <= '0;
            r_first <= 1'b1;
            if (!r_fiber_mode) begin
                r_last_seg <= '0;
                r_over     <= over;
            end else begin
                r_last_seg <= SEG_W'(nseg - 1'b1);
                r_over     <= '0;
            end
        end else if (r_state == S_UPDATE) begin
            r_seg   <= r_seg + 1'b1;
            r_first <= 1'b0;
            r_row   <= row_out;
        end
        if (r_state == S_UPDATE) begin
            r_out_seg  <= r_seg;
            r_out_hit  <= sel.hit;
            r_out_way  <= sel.way[WAY_OUT_W-1:0];
            r_out_over <= r_over;
            r_out_last <= seg_done;
        end
    end

    assign o_result_valid        = r_out_valid;
    assign o_segment             = r_out_seg;
    assign o_hit                 = r_out_hit;
    assign o_way_used            = r_out_way;
    assign o_overflow_miss_bytes = r_out_over;
    assign o_last                = r_out_last;

endmodule

// ===== dv/fiber_lru_cache_lookup_tb.sv =====
`timescale 1ns / 1ps

module fiber_lru_cache_lookup_tb;

    import flc_pkg::*;

    localparam int LINE_BYTES  = 16;
    localparam int WAYS        = 4;
    localparam int SETS        = 4096;
    localparam int MAX_BYTES   = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 50;

    localparam logic MODE_FIRST_LINE = 1'b0;
    localparam logic MODE_SPLIT      = 1'b1;

    typedef struct packed {
        logic [SEG_W-1:0]     segment;
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic [OVF_W-1:0]     ovf_bytes;
        logic                 last;
    } t_lookup_result;

    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] nbytes;
        logic               typed;
        t_lookup_result     want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic [ID_W-1:0] i_fiber_id = '0;
    logic [BYTES_W-1:0] i_fiber_bytes = '0;
    logic o_result_valid;
    logic [SEG_W-1:0] o_segment;
    logic o_hit;
    logic [WAY_OUT_W-1:0] o_way_used;
    logic [OVF_W-1:0] o_overflow_miss_bytes;
    logic o_last;

    // shadow of the tag store
    bit line_valid [SETS][WAYS];
    bit [16:0] line_tag [SETS][WAYS];
    bit [31:0] line_stamp [SETS][WAYS];
    bit [31:0] stamp_count = '0;
    logic cache_mode = MODE_SPLIT;

    t_lookup_result pending_results [$];
    int mismatch_count = 0;
    int stall_cycles = 0;
    logic [ID_W-1:0] recent_ids [16];

    // rows with a typed result are single-lookup cases readable at a glance
    t_directed_row directed_rows [20] = '{
        '{MODE_SPLIT,      23'h000000, 11'd0,    1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h000000, 11'd1,    1'b1, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b1}},
        '{MODE_SPLIT,      23'h000000, 11'd16,   1'b1, '{6'd0, 1'b1, 2'd0, 10'd0,    1'b1}},
        '{MODE_SPLIT,      23'h000000, 11'd17,   1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h7FFFFF, 11'd1024, 1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h7FFFFF, 11'd2047, 1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_FIRST_LINE, 23'h000123, 11'd2047, 1'b1, '{6'd0, 1'b0, 2'd0, 10'd1008, 1'b1}},
        '{MODE_FIRST_LINE, 23'h000123, 11'd0,    1'b1, '{6'd0, 1'b1, 2'd0, 10'd0,    1'b1}},
        '{MODE_FIRST_LINE, 23'h000123, 11'd16,   1'b1, '{6'd0, 1'b1, 2'd0, 10'd0,    1'b1}},
        '{MODE_FIRST_LINE, 23'h000123, 11'd17,   1'b1, '{6'd0, 1'b1, 2'd0, 10'd1,    1'b1}},
        '{MODE_FIRST_LINE, 23'h001123, 11'd1024, 1'b1, '{6'd0, 1'b0, 2'd1, 10'd1008, 1'b1}},
        '{MODE_FIRST_LINE, 23'h002123, 11'd5,    1'b1, '{6'd0, 1'b0, 2'd2, 10'd0,    1'b1}},
        '{MODE_FIRST_LINE, 23'h003123, 11'd0,    1'b1, '{6'd0, 1'b0, 2'd3, 10'd0,    1'b1}},
        '{MODE_FIRST_LINE, 23'h004123, 11'd1025, 1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_FIRST_LINE, 23'h000123, 11'd48,   1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_FIRST_LINE, 23'h7FFFFF, 11'd16,   1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h555555, 11'd1000, 1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h2AAAAA, 11'd15,   1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h400123, 11'd40,   1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}},
        '{MODE_SPLIT,      23'h7FFFFF, 11'd1009, 1'b0, '{6'd0, 1'b0, 2'd0, 10'd0,    1'b0}}
    };

    fiber_lru_cache_lookup DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_fiber_id            (i_fiber_id),
        .i_fiber_bytes         (i_fiber_bytes),
        .o_result_valid        (o_result_valid),
        .o_segment             (o_segment),
        .o_hit                 (o_hit),
        .o_way_used            (o_way_used),
        .o_overflow_miss_bytes (o_overflow_miss_bytes),
        .o_last                (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one line lookup: hit stamps the way, miss fills lowest invalid or oldest way
    function automatic void probe_set(input logic [11:0] set_idx, input logic [16:0] tag,
                                      output logic hit, output logic [1:0] way);
        bit found;
        bit [31:0] oldest;
        found = 1'b0;
        hit = 1'b0;
        way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
                found = 1'b1;
                hit = 1'b1;
                way = 2'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!found && !line_valid[set_idx][w]) begin
                found = 1'b1;
                way = 2'(w);
            end
        end
        if (!found) begin
            oldest = line_stamp[set_idx][0];
            for (int w = 1; w < WAYS; w++) begin
                if (line_stamp[set_idx][w] < oldest) begin
                    oldest = line_stamp[set_idx][w];
                    way = 2'(w);
                end
            end
        end
        if (!hit) begin
            line_valid[set_idx][way] = 1'b1;
            line_tag[set_idx][way] = tag;
        end
        stamp_count = stamp_count + 32'd1;
        line_stamp[set_idx][way] = stamp_count;
    endfunction

    task automatic cache_access(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] nbytes);
        logic [BYTES_W-1:0] len;
        int nseg;
        logic hit;
        logic [1:0] way;
        t_lookup_result res;
        len = (nbytes > MAX_BYTES) ? BYTES_W'(MAX_BYTES) : nbytes;
        if (cache_mode == MODE_FIRST_LINE) begin
            probe_set(id[11:0], {6'd0, id[22:12]}, hit, way);
            res.segment = '0;
            res.hit = hit;
            res.way_used = way;
            res.ovf_bytes = (len > LINE_BYTES) ? OVF_W'(len - LINE_BYTES) : '0;
            res.last = 1'b1;
            pending_results.push_back(res);
        end else begin
            nseg = (int'(len) + LINE_BYTES - 1) / LINE_BYTES;
            for (int s = 0; s < nseg; s++) begin
                // the segment index lands in the tag, the set stays the same
                probe_set(id[11:0], {6'(s), id[22:12]}, hit, way);
                res.segment = 6'(s);
                res.hit = hit;
                res.way_used = way;
                res.ovf_bytes = '0;
                res.last = (s + 1 == nseg);
                pending_results.push_back(res);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] nbytes,
                                input int gap, input logic typed, input t_lookup_result want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_fiber_id <= id;
        i_fiber_bytes <= nbytes;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        cache_access(id, nbytes);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
        // an empty fiber may still be in flight with nothing expected
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cache_mode = mode;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual segment %0d",
                         $time, o_segment);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("segment", 32'(want.segment), 32'(o_segment));
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("way_used", 32'(want.way_used), 32'(o_way_used));
                check_field("overflow_miss_bytes", 32'(want.ovf_bytes),
                            32'(o_overflow_miss_bytes));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [ID_W-1:0] id;
        logic [BYTES_W-1:0] nbytes;
        bit no_gaps;
        int r;
        int k;
        for (int i = 0; i < 16; i++)
            recent_ids[i] = {11'($urandom), 12'($urandom_range(0, 3) * 12'h3C1)};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass keeps busy high after reset
        @(posedge i_clk);
        @(negedge i_clk);
        while (busy !== 1'b0)
            @(negedge i_clk);
        set_mode(MODE_SPLIT);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != cache_mode)
                set_mode(directed_rows[i].mode);
            send_request(directed_rows[i].id, directed_rows[i].nbytes, pick_gap(),
                         directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_mode((p % 2 == 1) ? MODE_SPLIT : MODE_FIRST_LINE);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, 15);
                if (r < 55) begin
                    id = recent_ids[k];
                end else if (r < 80) begin
                    // same set, new tag: can force evictions
                    id = {11'($urandom), recent_ids[k][11:0]};
                    if ($urandom_range(0, 1) == 1)
                        recent_ids[k] = id;
                end else begin
                    id = ID_W'($urandom);
                    recent_ids[k] = id;
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                    nbytes = BYTES_W'($urandom_range(0, 64));
                else if (r < 92)
                    nbytes = BYTES_W'($urandom_range(65, MAX_BYTES));
                else
                    nbytes = BYTES_W'($urandom_range(MAX_BYTES + 1, 2047));
                send_request(id, nbytes, no_gaps ? 0 : pick_gap(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
